FILE: rtl/ntrq_pkg.sv
package ntrq_pkg;

   // field widths
   localparam int TIME_BITS      = 32;
   localparam int ROW_BITS       = 32;
   localparam int RPB_W          = 11;
   localparam int TPR_W          = 11;
   localparam int TRACK_IDX_W    = 4;
   localparam int TRACKS_USED_W  = 5;

   // block constants
   localparam int BEAT_TICKS     = 1920;
   localparam int MAX_TRACKS_DEF = 16;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_PER_BEAT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_ROW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ROW_TICK = 2'd2;

   localparam logic [RPB_W-1:0]     RPB_RESET = 11'd4;
   localparam logic [TPR_W-1:0]     TPR_RESET = 11'd480;
   localparam logic [TIME_BITS-1:0] FRT_RESET = '0;

   // quantizer arithmetic: signed tick offset, product with rows per beat
   localparam int D_W        = TIME_BITS + 2;
   localparam int PROD_W     = D_W + RPB_W + 1;
   localparam int MAG_W      = PROD_W - 1;
   localparam int DIGIT_BITS = 4;
   localparam int DIV_STEPS  = (MAG_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DIV_W      = DIV_STEPS * DIGIT_BITS;
   localparam int REM_W      = $clog2(BEAT_TICKS + 1) + 1;

   localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

   typedef struct packed {
      logic                 start_new;
      logic [TIME_BITS-1:0] on_tick;
      logic [TIME_BITS-1:0] off_tick;
   } req_payload_type;

   typedef struct packed {
      logic [TRACK_IDX_W-1:0]   track_index;
      logic                     dropped;
      logic [ROW_BITS-1:0]      row_on;
      logic [ROW_BITS-1:0]      row_off;
      logic [TRACKS_USED_W-1:0] tracks_used;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rd_en;
      logic scan_inc;
      logic place_hit;
      logic place_new;
      logic drop;
      logic out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_more;
      logic hit;
      logic room;
      logic quant_done;
      logic out_busy;
   } dp_status_type;

   // clamp a quotient to the row range
   function automatic logic [ROW_BITS-1:0] sat_row(input logic [DIV_W:0] v);
      if (v > (DIV_W + 1)'(ROW_MAX)) begin
         return ROW_MAX;
      end else begin
         return v[ROW_BITS-1:0];
      end
   endfunction

   // nearest rounding: remainder at or above half a beat rounds up
   function automatic logic round_up(input logic [REM_W-1:0] r);
      logic [REM_W:0] twice;
      twice = {r, 1'b0};
      return twice >= (REM_W + 1)'(BEAT_TICKS);
   endfunction

endpackage

FILE: rtl/ntrq_ram.sv
module ntrq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ntrq_div.sv
module ntrq_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ntrq_pkg::DIV_W-1:0] dividend,
   output logic [ntrq_pkg::DIV_W-1:0] quotient,
   output logic [ntrq_pkg::REM_W-1:0] remainder,
   output logic                       done
);
   import ntrq_pkg::*;

   localparam int STEP_CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [STEP_CW-1:0] LAST_STEP = STEP_CW'(DIV_STEPS - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dvd_t;
   logic [REM_W-1:0]   rem_t;

   // one digit of restoring division by the beat constant per cycle
   always_comb begin
      dvd_t = dvd_ff;
      rem_t = rem_ff;
      for (int k = 0; k < DIGIT_BITS; k++) begin
         rem_t = {rem_t[REM_W-2:0], dvd_t[DIV_W-1]};
         dvd_t = {dvd_t[DIV_W-2:0], 1'b0};
         if (rem_t >= REM_W'(BEAT_TICKS)) begin
            rem_t    = rem_t - REM_W'(BEAT_TICKS);
            dvd_t[0] = 1'b1;
         end
      end
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_t;
         rem_in = rem_t;
         cnt_in = cnt_ff + STEP_CW'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: rtl/ntrq_ctrl.sv
module ntrq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output ntrq_pkg::ctrl_cmd_type  cmd,
   input  ntrq_pkg::dp_status_type status
);
   import ntrq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_SCAN_RD  = 4'b0010,
      ST_SCAN_CMP = 4'b0100,
      ST_FINISH   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // first-fit scan sequencer
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (status.scan_more) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SCAN_CMP;
            end else if (status.room) begin
               cmd.place_new = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.drop = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_SCAN_CMP: begin
            if (status.hit) begin
               cmd.place_hit = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_FINISH: begin
            if (status.quant_done && !status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: rtl/ntrq_dp.sv
module ntrq_dp #(
   parameter int MAX_TRACKS = ntrq_pkg::MAX_TRACKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ntrq_pkg::ctrl_cmd_type          cmd,
   output ntrq_pkg::dp_status_type         status,
   input  ntrq_pkg::req_payload_type       req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ntrq_pkg::rsp_payload_type       rsp_payload,
   input  logic                            csr_write,
   input  logic [ntrq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ntrq_pkg::CSR_DATA_W-1:0] csr_data
);
   import ntrq_pkg::*;

   localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);

   function automatic logic [DIV_W-1:0] pos_part(input logic signed [PROD_W-1:0] p);
      if (p[PROD_W-1]) begin
         return '0;
      end else begin
         return DIV_W'(p[MAG_W-1:0]);
      end
   endfunction

   logic [RPB_W-1:0]         rpb_ff, rpb_in;
   logic [TPR_W-1:0]         tpr_ff, tpr_in;
   logic [TIME_BITS-1:0]     frt_ff, frt_in;
   logic [TIME_BITS-1:0]     on_ff, on_in;
   logic [TIME_BITS-1:0]     off_ff, off_in;
   logic [CNT_W-1:0]         open_ff, open_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [IDX_W-1:0]         track_ff, track_in;
   logic                     drop_ff, drop_in;
   logic signed [D_W-1:0]    d_on_ff, d_on_in;
   logic signed [D_W-1:0]    d_off_ff, d_off_in;
   logic signed [D_W-1:0]    d_late_ff, d_late_in;
   logic                     mul_ff, mul_in;
   logic                     go_ff, go_in;
   logic signed [PROD_W-1:0] p_on_ff, p_on_in;
   logic signed [PROD_W-1:0] p_off_ff, p_off_in;
   logic signed [PROD_W-1:0] p_late_ff, p_late_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_ff, rsp_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [TIME_BITS-1:0]     rd_data;
   logic [DIV_W-1:0]         q_on, q_off, q_late;
   logic [REM_W-1:0]         r_on, r_off, r_late;
   logic [2:0]               div_done;
   logic [ROW_BITS-1:0]      near_on, near_off, early_on, late_off;
   logic [ROW_BITS-1:0]      row_on, row_off;

   // track end store
   assign wr_en   = cmd.place_hit | cmd.place_new;
   assign wr_addr = cmd.place_hit ? scan_ff[IDX_W-1:0] : open_ff[IDX_W-1:0];

   ntrq_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_TRACKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (off_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // configuration registers
   always_comb begin
      rpb_in = rpb_ff;
      tpr_in = tpr_ff;
      frt_in = frt_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ROWS_PER_BEAT:  rpb_in = csr_data[RPB_W-1:0];
            CSR_TICKS_PER_ROW:  tpr_in = csr_data[TPR_W-1:0];
            CSR_FIRST_ROW_TICK: frt_in = csr_data[TIME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // note capture and track placement
   always_comb begin
      on_in    = on_ff;
      off_in   = off_ff;
      open_in  = open_ff;
      scan_in  = scan_ff;
      track_in = track_ff;
      drop_in  = drop_ff;
      if (cmd.load) begin
         on_in   = req_payload.on_tick;
         off_in  = req_payload.off_tick;
         scan_in = '0;
         if (req_payload.start_new) begin
            open_in = '0;
         end
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (cmd.place_hit) begin
         track_in = scan_ff[IDX_W-1:0];
         drop_in  = 1'b0;
      end
      if (cmd.place_new) begin
         track_in = open_ff[IDX_W-1:0];
         drop_in  = 1'b0;
         open_in  = open_ff + CNT_W'(1);
      end
      if (cmd.drop) begin
         track_in = '0;
         drop_in  = 1'b1;
      end
   end

   // offsets from row zero, then products with rows per beat
   always_comb begin
      d_on_in   = d_on_ff;
      d_off_in  = d_off_ff;
      d_late_in = d_late_ff;
      p_on_in   = p_on_ff;
      p_off_in  = p_off_ff;
      p_late_in = p_late_ff;
      if (cmd.load) begin
         d_on_in   = D_W'(req_payload.on_tick) - D_W'(frt_ff);
         d_off_in  = D_W'(req_payload.off_tick) - D_W'(frt_ff);
         d_late_in = D_W'(req_payload.off_tick) - D_W'(frt_ff) + D_W'(tpr_ff) - D_W'(1);
      end
      if (mul_ff) begin
         p_on_in   = PROD_W'(d_on_ff) * PROD_W'($signed({1'b0, rpb_ff}));
         p_off_in  = PROD_W'(d_off_ff) * PROD_W'($signed({1'b0, rpb_ff}));
         p_late_in = PROD_W'(d_late_ff) * PROD_W'($signed({1'b0, rpb_ff}));
      end
      mul_in = cmd.load;
      go_in  = mul_ff;
   end

   // division by ticks per beat, negative products give row zero
   ntrq_div u_div_on (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .dividend  (pos_part(p_on_ff)),
      .quotient  (q_on),
      .remainder (r_on),
      .done      (div_done[0])
   );

   ntrq_div u_div_off (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .dividend  (pos_part(p_off_ff)),
      .quotient  (q_off),
      .remainder (r_off),
      .done      (div_done[1])
   );

   ntrq_div u_div_late (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .dividend  (pos_part(p_late_ff)),
      .quotient  (q_late),
      .remainder (r_late),
      .done      (div_done[2])
   );

   // row candidates and the three-case rule against same-row notes
   always_comb begin
      early_on = sat_row({1'b0, q_on});
      near_on  = sat_row({1'b0, q_on} + (DIV_W + 1)'(round_up(r_on)));
      near_off = sat_row({1'b0, q_off} + (DIV_W + 1)'(round_up(r_off)));
      late_off = sat_row({1'b0, q_late});
      if (near_on == near_off && near_on != late_off) begin
         row_on  = near_on;
         row_off = late_off;
      end else if (near_on == near_off && early_on != near_off) begin
         row_on  = early_on;
         row_off = near_off;
      end else begin
         row_on  = near_on;
         row_off = near_off;
      end
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_in.track_index = TRACK_IDX_W'(track_ff);
         rsp_in.dropped     = drop_ff;
         rsp_in.row_on      = row_on;
         rsp_in.row_off     = row_off;
         rsp_in.tracks_used = TRACKS_USED_W'(open_ff);
         rsp_valid_in       = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpb_ff       <= RPB_RESET;
         tpr_ff       <= TPR_RESET;
         frt_ff       <= FRT_RESET;
         open_ff      <= '0;
         scan_ff      <= '0;
         mul_ff       <= 1'b0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rpb_ff       <= rpb_in;
         tpr_ff       <= tpr_in;
         frt_ff       <= frt_in;
         open_ff      <= open_in;
         scan_ff      <= scan_in;
         mul_ff       <= mul_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      on_ff     <= on_in;
      off_ff    <= off_in;
      track_ff  <= track_in;
      drop_ff   <= drop_in;
      d_on_ff   <= d_on_in;
      d_off_ff  <= d_off_in;
      d_late_ff <= d_late_in;
      p_on_ff   <= p_on_in;
      p_off_ff  <= p_off_in;
      p_late_ff <= p_late_in;
      rsp_ff    <= rsp_in;
   end

   // status to the controller
   assign status.scan_more  = (scan_ff < open_ff);
   assign status.hit        = (rd_data <= on_ff);
   assign status.room       = (open_ff < CNT_W'(MAX_TRACKS));
   assign status.quant_done = !mul_ff && !go_ff && (&div_done);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/note_track_first_fit_row_quantizer_top.sv
// the first-fit scan spends one ram read and one compare per open track
// rows come from three dividers by ticks per beat, four quotient bits a cycle
// one note at a time, a waiting result does not block accept
// synchronous active-high reset clears handshake state, open track count and config registers;
// the track end store is not cleared, entries are written as tracks open
module note_track_first_fit_row_quantizer_top #(
   parameter int MAX_TRACKS = ntrq_pkg::MAX_TRACKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ntrq_pkg::req_payload_type       req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ntrq_pkg::rsp_payload_type       rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ntrq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ntrq_pkg::CSR_DATA_W-1:0] csr_data
);
   import ntrq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   ntrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ntrq_dp #(
      .MAX_TRACKS (MAX_TRACKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule

FILE: rtl/ntrq_checker.sv
module ntrq_checker #(
   parameter int MAX_TRACKS = ntrq_pkg::MAX_TRACKS_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input ntrq_pkg::rsp_payload_type rsp_payload
);
   import ntrq_pkg::*;

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays in place
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // one note at a time: busy right after a transfer in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second note taken while busy");

   // a dropped note only with every track open, and on track zero
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.dropped |->
         rsp_payload.track_index == '0 &&
         rsp_payload.tracks_used == TRACKS_USED_W'(MAX_TRACKS))
      else $error("drop without full track set");

   // a placed note lies on an open track, checked only for up to 15 tracks
   a_track_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.dropped && (MAX_TRACKS <= 15) |->
         TRACKS_USED_W'(rsp_payload.track_index) < rsp_payload.tracks_used)
      else $error("note placed beyond open tracks");

endmodule

bind note_track_first_fit_row_quantizer_top ntrq_checker #(
   .MAX_TRACKS (MAX_TRACKS)
) u_ntrq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
